// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mdiom_pkg.sv =====
package mdiom_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [2:0] FT_C22_READ     = 3'd0;
  localparam logic [2:0] FT_C22_WRITE    = 3'd1;
  localparam logic [2:0] FT_C45_ADDRESS  = 3'd2;
  localparam logic [2:0] FT_C45_WRITE    = 3'd3;
  localparam logic [2:0] FT_C45_READ     = 3'd4;
  localparam logic [2:0] FT_C45_READ_INC = 3'd5;

  localparam logic [6:0] MAX_PREAMBLE = 7'd64;
  localparam logic [6:0] WRITE_TAIL   = 7'd33;
  localparam logic [6:0] READ_TAIL    = 7'd32;
  localparam logic [6:0] READ_TA_POS  = 7'd18;
  localparam logic [6:0] LAST_POS     = 7'd1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic        active;
    logic [6:0]  bit_pos;
    logic [31:0] send_shift;
    logic [15:0] recv_shift;
    logic [2:0]  cur_frame;
    logic [15:0] last_read;
  } mdiom_state_t;

  typedef struct packed {
    logic        request_rejected;
    logic [15:0] read_data;
    logic        frame_done;
    logic        busy_res;
    logic        mdio_drive;
    logic        mdio_out;
    logic        mdc_pulse;
  } mdiom_result_t;

  function automatic logic [3:0] start_code(input logic [2:0] ftype);
    logic [3:0] code;
    case (ftype)
      FT_C22_READ:     code = 4'b0110;
      FT_C22_WRITE:    code = 4'b0101;
      FT_C45_ADDRESS:  code = 4'b0000;
      FT_C45_WRITE:    code = 4'b0001;
      FT_C45_READ:     code = 4'b0011;
      FT_C45_READ_INC: code = 4'b0010;
      default:         code = 4'b0000;
    endcase
    return code;
  endfunction

  function automatic logic is_read(input logic [2:0] ftype);
    return (ftype == FT_C22_READ) || (ftype == FT_C45_READ) || (ftype == FT_C45_READ_INC);
  endfunction

endpackage

// ===== hdl/mdiom_step.sv =====
module mdiom_step (
  input  mdiom_pkg::mdiom_state_t  st,
  input  logic                     opcode,
  input  logic [2:0]               frame_type,
  input  logic [4:0]               phy_address,
  input  logic [4:0]               reg_address,
  input  logic [15:0]              write_data,
  input  logic                     mdio_in,
  input  logic [6:0]               preamble_bits,
  output mdiom_pkg::mdiom_state_t  st_nxt,
  output mdiom_pkg::mdiom_result_t res
);
  import mdiom_pkg::*;

  logic [6:0] pre;
  logic [6:0] tail;
  logic       rd_new;
  logic       rd_cur;

  always_comb begin
    pre    = (preamble_bits > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_bits;
    rd_new = is_read(frame_type);
    rd_cur = is_read(st.cur_frame);
    tail   = rd_cur ? READ_TAIL : WRITE_TAIL;
    st_nxt = st;
    res    = '0;
    if (opcode == OP_START) begin
      if (st.active || (frame_type > FT_C45_READ_INC)) begin
        res.request_rejected = 1'b1;
      end else begin
        st_nxt.cur_frame  = frame_type;
        st_nxt.send_shift = {start_code(frame_type), phy_address, reg_address,
                             rd_new ? 18'h0 : {2'b10, write_data}};
        st_nxt.recv_shift = '0;
        st_nxt.bit_pos    = pre + (rd_new ? READ_TAIL : WRITE_TAIL);
        st_nxt.active     = 1'b1;
      end
    end else if (st.active) begin
      res.mdc_pulse = 1'b1;
      if (st.bit_pos > tail) begin
        // preamble
        res.mdio_out   = 1'b1;
        res.mdio_drive = 1'b1;
      end else if (st.bit_pos == LAST_POS) begin
        res.frame_done = 1'b1;
        st_nxt.active  = 1'b0;
        if (rd_cur) begin
          st_nxt.last_read = st.recv_shift;
        end
      end else if (!rd_cur || (st.bit_pos > READ_TA_POS)) begin
        res.mdio_out      = st.send_shift[31];
        res.mdio_drive    = 1'b1;
        st_nxt.send_shift = {st.send_shift[30:0], 1'b0};
      end else if (st.bit_pos < READ_TA_POS) begin
        st_nxt.recv_shift = {st.recv_shift[14:0], mdio_in};
      end
      st_nxt.bit_pos = st.bit_pos - 7'd1;
    end
    res.busy_res  = st_nxt.active;
    res.read_data = st_nxt.last_read;
  end

endmodule

// ===== hdl/mdio_management_frame_master_top.sv =====
// channel   | dir | handshake              | payload
// in_       | in  | in_tvalid / in_tready  | tuser opcode, tdata request and tick fields
// out_      | out | out_tvalid / out_tready| tdata one result word per input word
// cfg_      | in  | cfg_wr_en              | cfg_wr_data preamble length
//
// one word per cycle while in_tready is high: every input word produces its result word in the next cycle
// the frame state register and the output register are the only pipeline stages
// in_tready drops only while the output register holds a word that is not taken
// rst_n (synchronous) clears the frame state, last read value and output valid
// preamble length resets to 64
module mdio_management_frame_master_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] frame_type, [7:3] phy_address, [12:8] reg_address, [28:13] write_data,
  // [29] mdio_in, [31:30] zero
  input  logic [mdiom_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] mdc_pulse, [1] mdio_out, [2] mdio_drive, [3] busy_res, [4] frame_done,
  // [20:5] read_data, [21] request_rejected, [23:22] zero
  output logic [mdiom_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [6:0]                       cfg_wr_data
);
  import mdiom_pkg::*;

  mdiom_state_t  state_r;
  mdiom_state_t  state_nxt;
  mdiom_result_t res;
  mdiom_result_t out_res_r;
  logic          out_valid_r;
  logic [6:0]    preamble_r;
  logic          in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  mdiom_step u_step (
    .st            (state_r),
    .opcode        (in_tuser),
    .frame_type    (in_tdata[2:0]),
    .phy_address   (in_tdata[7:3]),
    .reg_address   (in_tdata[12:8]),
    .write_data    (in_tdata[28:13]),
    .mdio_in       (in_tdata[29]),
    .preamble_bits (preamble_r),
    .st_nxt        (state_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= MAX_PREAMBLE;
    end else if (cfg_wr_en) begin
      preamble_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  `include "assert_macros.svh"

  `ASSERT_CLK(a_pos_tracks_active, state_r.active == (state_r.bit_pos != 7'd0), "bit position out of step with active")
  `ASSERT_CLK(a_drive_needs_pulse, !out_valid_r || !out_res_r.mdio_drive || out_res_r.mdc_pulse, "mdio driven without mdc pulse")
  `ASSERT_CLK(a_done_ends_frame, !out_valid_r || !out_res_r.frame_done || (out_res_r.mdc_pulse && !out_res_r.busy_res), "frame done while still busy")
  `ASSERT_NEXT(a_start_goes_busy, in_fire && (in_tuser == OP_START) && !state_r.active && (in_tdata[2:0] <= FT_C45_READ_INC), state_r.active, "valid start did not begin a frame")

endmodule
